### rtl/fwss_pkg.sv
// Shared types and constants for the state queue with membership search.
package fwss_pkg;

   localparam int STATE_BITS = 64;
   localparam int EIU_BITS   = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam logic [EIU_BITS-1:0] EIU_RESET = 5'd9;

   // Register index is taken from the word address bit of paddr.
   localparam logic REG_ELEMENTS_IN_USE = 1'b0;

   typedef enum logic [1:0] {
      KIND_PUSH   = 2'd0,
      KIND_POP    = 2'd1,
      KIND_SEARCH = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_SEARCH
   } fsm_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [STATE_BITS-1:0] state_word;
   } req_type;

   typedef struct packed {
      logic [STATE_BITS-1:0] popped_state;
      logic                  pop_valid;
      logic                  found;
      logic                  empty_flag;
      logic                  full_refused;
   } rsp_type;

endpackage

### rtl/fwss_match.sv
// Search key and compare mask registers with the masked equality compare.
module fwss_match
   import fwss_pkg::*;
#(
   parameter int TILE_COUNT = 16,
   parameter int TILE_BITS  = 4
) (
   input  logic                  clock,
   input  logic                  load,
   input  logic [EIU_BITS-1:0]   count,
   input  logic [STATE_BITS-1:0] key,
   input  logic [STATE_BITS-1:0] entry,
   output logic                  hit
);

   localparam int WIDTH_BITS = 8;

   logic [STATE_BITS-1:0] key_ff;
   logic [STATE_BITS-1:0] mask_ff;
   logic [STATE_BITS-1:0] mask_in;
   logic [EIU_BITS-1:0]   count_sat;
   logic [WIDTH_BITS-1:0] cmp_bits;

   // The count saturates at the tile count; a compared width past the word covers it all.
   assign count_sat = (count > EIU_BITS'(TILE_COUNT)) ? EIU_BITS'(TILE_COUNT) : count;
   assign cmp_bits  = WIDTH_BITS'({3'b000, count_sat} * WIDTH_BITS'(TILE_BITS));

   for (genvar b = 0; b < STATE_BITS; b++) begin : g_mask
      assign mask_in[b] = (WIDTH_BITS'(b) < cmp_bits);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         key_ff  <= key;
         mask_ff <= mask_in;
      end
   end

   assign hit = (((entry ^ key_ff) & mask_ff) == '0);

endmodule

### rtl/fifo_with_state_search_top.sv
// Top level: state queue held in one synchronous memory, with a sequential search.
// Timing: push, clear, and a pop or search that finds nothing to do give their result in the
// cycle after acceptance; a pop answers after its memory read, through ST_POP_WAIT; a search
// compares the stored entries in order, ending early on a hit (busy high meanwhile).
// Throughput: when idle, push and clear accept one transaction per cycle; a search scans one
// entry per cycle through the single memory read port. Reset clears the pointers,
// the occupancy and the result strobe and sets elements_in_use to 9; the memory is not cleared.
module fifo_with_state_search_top
   import fwss_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64,
   parameter int TILE_COUNT  = 16,
   parameter int TILE_BITS   = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int OCC_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [OCC_BITS-1:0] FULL_OCC  = OCC_BITS'(QUEUE_DEPTH);

   logic [STATE_BITS-1:0] entries_mem [QUEUE_DEPTH];
   logic [STATE_BITS-1:0] rd_data_ff;

   fsm_type             state_ff, state_in;
   logic [PTR_BITS-1:0] head_ff, head_in;
   logic [PTR_BITS-1:0] tail_ff, tail_in;
   logic [OCC_BITS-1:0] occ_ff, occ_in;
   logic [PTR_BITS-1:0] scan_addr_ff, scan_addr_in;
   logic [OCC_BITS-1:0] remain_ff, remain_in;
   logic [EIU_BITS-1:0] eiu_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                accept;
   logic                mem_we;
   logic                rd_en;
   logic [PTR_BITS-1:0] rd_addr;
   logic                match_load;
   logic                match_hit;
   logic                csr_write;

   function automatic logic [PTR_BITS-1:0] next_slot(input logic [PTR_BITS-1:0] idx);
      next_slot = (idx == LAST_SLOT) ? '0 : idx + 1'b1;
   endfunction

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Configuration port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_ELEMENTS_IN_USE)
                      ? {{(CSR_DATA_BITS-EIU_BITS){1'b0}}, eiu_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eiu_ff <= EIU_RESET;
      end else if (csr_write && paddr[2] == REG_ELEMENTS_IN_USE) begin
         eiu_ff <= pwdata[EIU_BITS-1:0];
      end
   end

   // Writes happen only on a push taken in idle and reads are issued only from a
   // pop or search, so the two ports never touch the same entry in one cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_mem[tail_ff] <= req_data.state_word;
      end
      if (rd_en) begin
         rd_data_ff <= entries_mem[rd_addr];
      end
   end

   fwss_match #(
      .TILE_COUNT (TILE_COUNT),
      .TILE_BITS  (TILE_BITS)
   ) u_match (
      .clock (clock),
      .load  (match_load),
      .count (eiu_ff),
      .key   (req_data.state_word),
      .entry (rd_data_ff),
      .hit   (match_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      remain_ff    <= remain_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      scan_addr_in = scan_addr_ff;
      remain_in    = remain_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      match_load   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (kind_type'(req_data.kind))
                  KIND_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (occ_ff == FULL_OCC) begin
                        rsp_in.full_refused = 1'b1;
                     end else begin
                        mem_we  = 1'b1;
                        tail_in = next_slot(tail_ff);
                        occ_in  = occ_ff + 1'b1;
                     end
                  end
                  KIND_POP: begin
                     if (occ_ff == '0) begin
                        rsp_valid_in      = 1'b1;
                        rsp_in.empty_flag = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        head_in  = next_slot(head_ff);
                        occ_in   = occ_ff - 1'b1;
                        state_in = ST_POP_WAIT;
                     end
                  end
                  KIND_SEARCH: begin
                     if (occ_ff == '0 || eiu_ff == '0) begin
                        rsp_valid_in      = 1'b1;
                        rsp_in.empty_flag = (occ_ff == '0);
                     end else begin
                        rd_en        = 1'b1;
                        match_load   = 1'b1;
                        scan_addr_in = next_slot(head_ff);
                        remain_in    = occ_ff;
                        state_in     = ST_SEARCH;
                     end
                  end
                  KIND_CLEAR: begin
                     head_in           = '0;
                     tail_in           = '0;
                     occ_in            = '0;
                     rsp_valid_in      = 1'b1;
                     rsp_in.empty_flag = 1'b1;
                  end
               endcase
            end
         end
         ST_POP_WAIT: begin
            rsp_valid_in        = 1'b1;
            rsp_in.popped_state = rd_data_ff;
            rsp_in.pop_valid    = 1'b1;
            rsp_in.empty_flag   = (occ_ff == '0);
            state_in            = ST_IDLE;
         end
         ST_SEARCH: begin
            // One entry is compared per cycle while the next read is already issued.
            rd_en        = 1'b1;
            rd_addr      = scan_addr_ff;
            scan_addr_in = next_slot(scan_addr_ff);
            remain_in    = remain_ff - 1'b1;
            if (match_hit || remain_ff == OCC_BITS'(1)) begin
               rsp_valid_in = 1'b1;
               rsp_in.found = match_hit;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/fwss_checker.sv
// Port-level assertions for the state queue, bound to the top level.
module fwss_checker
   import fwss_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // Every accepted transaction either answers in the next cycle or holds busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid || busy)
      else $error("accepted transaction neither answered nor went busy");

   // A transaction that raises busy answers only at the edge that ends busy.
   a_no_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result strobe while busy");

   a_busy_ends_with_rsp: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("busy ended without a result");

   // A transaction yields at most one of pop, hit and refusal; a refused push means a full queue.
   a_result_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_data.pop_valid, rsp_data.found,
                                rsp_data.full_refused}) <= 1 &&
                    !(rsp_data.full_refused && rsp_data.empty_flag))
      else $error("inconsistent result flags");

   a_popped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.pop_valid |-> rsp_data.popped_state == '0)
      else $error("popped state not zero without a pop");

endmodule

bind fifo_with_state_search_top fwss_checker u_fwss_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

### tb/tb_fifo_with_state_search_top.sv
// Self-checking testbench for the state queue with membership search.
`timescale 1ns / 1ps

module tb_fifo_with_state_search_top;
   import fwss_pkg::*;

   localparam int QDEPTH         = 64;
   localparam int TILE_N         = 16;
   localparam int TILE_W         = 4;
   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 12;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 240;
   localparam int DRAIN_CYCLES   = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_ROWS       = 32;
   localparam logic [STATE_BITS-1:0] FILL_BASE = 64'h0123_4567_89AB_CDEF;
   localparam logic [STATE_BITS-1:0] FILL_STEP = 64'h0101_0101_0101_0101;
   localparam logic [CSR_ADDR_BITS-1:0] EIU_ADDR   = {REG_ELEMENTS_IN_USE, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] SPARE_ADDR = {~REG_ELEMENTS_IN_USE, 2'b00};

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_FILL,
      ROW_CSR
   } row_act_type;

   typedef struct {
      row_act_type              act;
      kind_type                 kind;
      logic [STATE_BITS-1:0]    word;
      logic [CSR_ADDR_BITS-1:0] addr;
      logic                     pin;
      rsp_type                  exp;
   } stim_row_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     start     = 1'b0;
   logic                     busy;
   req_type                  req_data  = '0;
   logic                     rsp_valid;
   rsp_type                  rsp_data;
   logic                     psel      = 1'b0;
   logic                     penable   = 1'b0;
   logic                     pwrite    = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr     = '0;
   logic [CSR_DATA_BITS-1:0] pwdata    = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // Table rows may pin the expected result; it travels with the transaction.
   logic    req_pinned     = 1'b0;
   rsp_type req_pinned_rsp = '0;

   // Predictor state.
   logic [STATE_BITS-1:0] slots [QDEPTH];
   int unsigned           q_head  = 0;
   int unsigned           q_tail  = 0;
   int unsigned           q_count = 0;
   logic [EIU_BITS-1:0]   cur_eiu = EIU_RESET;
   rsp_type               rsp_expected [$];

   stim_row_type dir_rows [MAX_ROWS];
   int unsigned  row_count    = 0;
   bit           gaps_on      = 1'b1;
   int unsigned  mismatches   = 0;
   int unsigned  idle_cycles  = 0;
   int unsigned  results_seen = 0;
   int unsigned  csr_writes   = 0;
   int unsigned  n_push = 0, n_refused = 0, n_pop = 0, n_popped = 0;
   int unsigned  n_search = 0, n_hits = 0, n_clear = 0;

   always #(HALF_PERIOD) clock = ~clock;

   fifo_with_state_search_top #(
      .QUEUE_DEPTH(QDEPTH),
      .TILE_COUNT (TILE_N),
      .TILE_BITS  (TILE_W)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   function automatic logic [STATE_BITS-1:0] search_mask(input logic [EIU_BITS-1:0] eiu);
      int unsigned tiles;
      tiles = (eiu > TILE_N) ? TILE_N : eiu;
      if (tiles * TILE_W >= STATE_BITS) return '1;
      return (64'd1 << (tiles * TILE_W)) - 64'd1;
   endfunction

   function automatic rsp_type rsp_of(input logic [STATE_BITS-1:0] popped, input logic pv,
                                      input logic hit, input logic emp, input logic refused);
      rsp_type r;
      r.popped_state = popped;
      r.pop_valid    = pv;
      r.found        = hit;
      r.empty_flag   = emp;
      r.full_refused = refused;
      return r;
   endfunction

   // Applies one accepted transaction to the queue image and returns its result.
   function automatic rsp_type apply_queue_op(input req_type r);
      rsp_type               o;
      logic [STATE_BITS-1:0] mask;
      int unsigned           pos;
      int unsigned           n;
      o = '0;
      case (r.kind)
         KIND_PUSH: begin
            n_push++;
            if (q_count >= QDEPTH) begin
               o.full_refused = 1'b1;
               n_refused++;
            end else begin
               slots[q_tail] = r.state_word;
               q_tail = (q_tail + 1) % QDEPTH;
               q_count++;
            end
         end
         KIND_POP: begin
            n_pop++;
            if (q_count != 0) begin
               o.popped_state = slots[q_head];
               o.pop_valid = 1'b1;
               q_head = (q_head + 1) % QDEPTH;
               q_count--;
               n_popped++;
            end
         end
         KIND_SEARCH: begin
            n_search++;
            if (cur_eiu != 0) begin
               mask = search_mask(cur_eiu);
               pos = q_head;
               for (n = 0; n < q_count && !o.found; n++) begin
                  if (((slots[pos] ^ r.state_word) & mask) == '0) o.found = 1'b1;
                  pos = (pos + 1) % QDEPTH;
               end
               if (o.found) n_hits++;
            end
         end
         default: begin
            n_clear++;
            q_head = 0;
            q_tail = 0;
            q_count = 0;
         end
      endcase
      o.empty_flag = (q_count == 0);
      return o;
   endfunction

   // Half the states use tiles of 0 or 1 only, so that partial matches are common.
   function automatic logic [STATE_BITS-1:0] random_state();
      logic [STATE_BITS-1:0] w;
      int                    i;
      w = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 0) begin
         for (i = 0; i < TILE_N; i++) w[i*TILE_W +: TILE_W] = $urandom_range(0, 1);
      end
      return w;
   endfunction

   function automatic logic [STATE_BITS-1:0] search_probe();
      logic [STATE_BITS-1:0] w;
      logic [STATE_BITS-1:0] m;
      int unsigned           pick;
      w = random_state();
      if (q_count != 0 && $urandom_range(0, 3) != 0) begin
         pick = (q_head + $urandom_range(0, q_count - 1)) % QDEPTH;
         m = search_mask(cur_eiu);
         w = (slots[pick] & m) | (w & ~m);
         if ($urandom_range(0, 3) == 0) w = w ^ (64'd1 << $urandom_range(0, STATE_BITS - 1));
      end
      return w;
   endfunction

   task automatic check_field(input string name, input logic [STATE_BITS-1:0] exp_v,
                              input logic [STATE_BITS-1:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         mismatches++;
      end
   endtask

   task automatic add_row(input row_act_type act, input kind_type kind,
                          input logic [STATE_BITS-1:0] word,
                          input logic [CSR_ADDR_BITS-1:0] addr,
                          input logic pin, input rsp_type exp);
      dir_rows[row_count].act  = act;
      dir_rows[row_count].kind = kind;
      dir_rows[row_count].word = word;
      dir_rows[row_count].addr = addr;
      dir_rows[row_count].pin  = pin;
      dir_rows[row_count].exp  = exp;
      row_count++;
   endtask

   // Predicts and checks at every rising edge, from the values held before the edge.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type pred;
      if (!reset) begin
         if (rsp_valid) begin
            if (rsp_expected.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = rsp_expected.pop_front();
               check_field("popped_state", want.popped_state, rsp_data.popped_state);
               check_field("pop_valid", want.pop_valid, rsp_data.pop_valid);
               check_field("found", want.found, rsp_data.found);
               check_field("empty_flag", want.empty_flag, rsp_data.empty_flag);
               check_field("full_refused", want.full_refused, rsp_data.full_refused);
               results_seen++;
            end
         end
         if (start && !busy) begin
            pred = apply_queue_op(req_data);
            rsp_expected.push_back(req_pinned ? req_pinned_rsp : pred);
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr == EIU_ADDR) cur_eiu = pwdata[EIU_BITS-1:0];
            csr_writes++;
         end
      end
      if (rsp_valid || (start && !busy) || (psel && penable && pready)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
   end

   // Leaves start high, or low after a gap; the caller's next drive is in the same step.
   task automatic send_item(input kind_type k, input logic [STATE_BITS-1:0] w,
                            input logic pin, input rsp_type pr);
      req_type r;
      r.kind = k;
      r.state_word = w;
      start <= 1'b1;
      req_data <= r;
      req_pinned <= pin;
      req_pinned_rsp <= pr;
      do @(posedge clock); while (busy);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Every transaction yields a result, so the block is idle once none is pending.
   task automatic wait_idle();
      @(posedge clock);
      while (rsp_expected.size() != 0 || busy) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_update(input logic [CSR_ADDR_BITS-1:0] addr,
                             input logic [CSR_DATA_BITS-1:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pwrite <= 1'b0;
      penable <= 1'b0;
      paddr <= EIU_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {{(CSR_DATA_BITS-EIU_BITS){1'b0}}, cur_eiu}) begin
         $display("%0t: elements_in_use readback mismatch, expected %h, actual %h",
                  $time, cur_eiu, prdata);
         mismatches++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      int unsigned           row_i;
      int unsigned           ph;
      int unsigned           n;
      int unsigned           fill_i;
      int unsigned           pick;
      int unsigned           push_cut;
      int unsigned           pop_cut;
      int unsigned           clear_permille;
      logic [STATE_BITS-1:0] w;
      logic [EIU_BITS-1:0]   eiu_pick;
      kind_type              k;
      stim_row_type          row;

      // Directed rows; elements_in_use is 9 after reset.
      add_row(ROW_ITEM, KIND_POP, '0, EIU_ADDR, 1'b1, rsp_of('0, 0, 0, 1, 0));
      add_row(ROW_ITEM, KIND_SEARCH, '1, EIU_ADDR, 1'b1, rsp_of('0, 0, 0, 1, 0));
      add_row(ROW_ITEM, KIND_PUSH, '1, EIU_ADDR, 1'b1, rsp_of('0, 0, 0, 0, 0));
      add_row(ROW_ITEM, KIND_PUSH, '0, EIU_ADDR, 1'b1, rsp_of('0, 0, 0, 0, 0));
      add_row(ROW_ITEM, KIND_SEARCH, 64'h0000_000F_FFFF_FFFF, EIU_ADDR, 1'b0, '0);
      add_row(ROW_ITEM, KIND_SEARCH, 64'h0000_000F_0000_0000, EIU_ADDR, 1'b0, '0);
      // A zero compare count never matches, even against an identical entry.
      add_row(ROW_CSR, KIND_PUSH, 64'd0, EIU_ADDR, 1'b0, '0);
      add_row(ROW_ITEM, KIND_SEARCH, '0, EIU_ADDR, 1'b1, rsp_of('0, 0, 0, 0, 0));
      // A count above the tile count saturates to a full-word compare.
      add_row(ROW_CSR, KIND_PUSH, 64'd31, EIU_ADDR, 1'b0, '0);
      add_row(ROW_ITEM, KIND_SEARCH, 64'h8000_0000_0000_0000, EIU_ADDR, 1'b0, '0);
      add_row(ROW_CSR, KIND_PUSH, 64'd1, SPARE_ADDR, 1'b0, '0);
      add_row(ROW_ITEM, KIND_SEARCH, 64'h0000_0000_0000_0001, EIU_ADDR, 1'b0, '0);
      add_row(ROW_CSR, KIND_PUSH, 64'd1, EIU_ADDR, 1'b0, '0);
      add_row(ROW_ITEM, KIND_SEARCH, 64'h1234_5678_9ABC_DEF0, EIU_ADDR, 1'b0, '0);
      add_row(ROW_CSR, KIND_PUSH, 64'd16, EIU_ADDR, 1'b0, '0);
      add_row(ROW_ITEM, KIND_POP, '0, EIU_ADDR, 1'b1, rsp_of('1, 1, 0, 0, 0));
      add_row(ROW_ITEM, KIND_POP, '1, EIU_ADDR, 1'b1, rsp_of('0, 1, 0, 1, 0));
      add_row(ROW_ITEM, KIND_PUSH, 64'hA5A5_5A5A_C3C3_3C3C, EIU_ADDR, 1'b0, '0);
      add_row(ROW_ITEM, KIND_CLEAR, '0, EIU_ADDR, 1'b1, rsp_of('0, 0, 0, 1, 0));
      add_row(ROW_ITEM, KIND_SEARCH, 64'hA5A5_5A5A_C3C3_3C3C, EIU_ADDR, 1'b1,
              rsp_of('0, 0, 0, 1, 0));
      add_row(ROW_FILL, KIND_PUSH, FILL_BASE, EIU_ADDR, 1'b0, '0);
      add_row(ROW_ITEM, KIND_PUSH, 64'hFFFF_0000_FFFF_0000, EIU_ADDR, 1'b1,
              rsp_of('0, 0, 0, 0, 1));
      add_row(ROW_ITEM, KIND_SEARCH, FILL_BASE ^ (63 * FILL_STEP), EIU_ADDR, 1'b0, '0);
      add_row(ROW_ITEM, KIND_SEARCH, 64'hDEAD_BEEF_DEAD_BEEF, EIU_ADDR, 1'b0, '0);
      add_row(ROW_ITEM, KIND_POP, '0, EIU_ADDR, 1'b0, '0);
      add_row(ROW_ITEM, KIND_PUSH, 64'h5555_AAAA_5555_AAAA, EIU_ADDR, 1'b0, '0);
      add_row(ROW_ITEM, KIND_CLEAR, '1, EIU_ADDR, 1'b1, rsp_of('0, 0, 0, 1, 0));
      add_row(ROW_CSR, KIND_PUSH, 64'd9, EIU_ADDR, 1'b0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row_i = 0; row_i < row_count; row_i++) begin
         row = dir_rows[row_i];
         case (row.act)
            ROW_CSR: begin
               start <= 1'b0;
               wait_idle();
               csr_update(row.addr, row.word[CSR_DATA_BITS-1:0]);
            end
            ROW_FILL: begin
               for (fill_i = 0; fill_i < QDEPTH; fill_i++)
                  send_item(KIND_PUSH, row.word ^ (fill_i * FILL_STEP), 1'b0, '0);
            end
            default: send_item(row.kind, row.word, row.pin, row.exp);
         endcase
      end

      // Random phases alternate filling, mixed and draining traffic.
      for (ph = 0; ph < PHASES; ph++) begin
         start <= 1'b0;
         wait_idle();
         case (ph)
            0: eiu_pick = 1;
            1: eiu_pick = 16;
            2: eiu_pick = 0;
            3: eiu_pick = 31;
            4: eiu_pick = 17;
            5: eiu_pick = 9;
            default: eiu_pick = $urandom_range(0, 31);
         endcase
         csr_update(EIU_ADDR, ($urandom & ~32'h1F) | eiu_pick);
         if (ph == 4) begin
            // The bus returns to idle for one cycle before the next transfer starts.
            @(posedge clock);
            csr_update(SPARE_ADDR, $urandom);
         end
         case (ph % 3)
            0: begin
               push_cut = 65;
               pop_cut = 80;
               clear_permille = 3;
            end
            1: begin
               push_cut = 40;
               pop_cut = 65;
               clear_permille = 20;
            end
            default: begin
               push_cut = 20;
               pop_cut = 65;
               clear_permille = 20;
            end
         endcase
         gaps_on = (ph != 2) && (ph < PHASES - 1);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 999) < clear_permille) k = KIND_CLEAR;
            else if (pick < push_cut) k = KIND_PUSH;
            else if (pick < pop_cut) k = KIND_POP;
            else k = KIND_SEARCH;
            w = (k == KIND_SEARCH) ? search_probe() : random_state();
            send_item(k, w, 1'b0, '0);
         end
      end

      start <= 1'b0;
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rsp_expected.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, rsp_expected.size());
         mismatches++;
      end
      $display("Covered %0d transactions: %0d push (%0d refused when full), %0d pop (%0d %s",
               n_push + n_pop + n_search + n_clear, n_push, n_refused, n_pop, n_popped,
               $sformatf("with data), %0d search (%0d hits), %0d clear.", n_search, n_hits,
                         n_clear));
      $display("Checked %0d results over %0d register writes, %0d mismatches.",
               results_seen, csr_writes, mismatches);
      if (mismatches == 0) begin
         $display("tb_fifo_with_state_search_top: PASS");
      end else begin
         $display("tb_fifo_with_state_search_top: FAIL");
      end
      $finish;
   end

   initial begin
      do @(posedge clock); while (idle_cycles < WATCHDOG_LIMIT);
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_fifo_with_state_search_top: FAIL");
      $finish;
   end

endmodule

### files.f
rtl/fwss_pkg.sv
rtl/fwss_match.sv
rtl/fifo_with_state_search_top.sv
rtl/fwss_checker.sv
tb/tb_fifo_with_state_search_top.sv
